### rtl/core/msadpcm_pkg.sv
// Shared types, codes and constants of the ADPCM block decoder.
package msadpcm_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CHANNELS  = 2'd0;
  localparam logic [1:0] CFG_FRAMES    = 2'd1;
  localparam logic [1:0] CFG_COEF_SETS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [1:0]  CHANNELS_RESET  = 2'd1;
  localparam logic [15:0] FRAMES_RESET    = 16'd500;
  localparam logic [7:0]  COEF_SETS_RESET = 8'd7;

  // Channel count code that selects stereo.
  localparam logic [1:0] CHANNELS_STEREO = 2'd2;

  // Header lengths in bytes for mono and stereo.
  localparam logic [3:0] HDR_LEN_MONO   = 4'd7;
  localparam logic [3:0] HDR_LEN_STEREO = 4'd14;

  // Smallest step size after adaptation.
  localparam logic [17:0] STEP_FLOOR = 18'd16;

  // Saturation limits of a decoded sample.
  localparam logic signed [25:0] SAMPLE_MAX = 26'sd32767;
  localparam logic signed [25:0] SAMPLE_MIN = -26'sd32768;

  // Header field groups after the predictor bytes.
  localparam logic [1:0] GRP_STEP  = 2'd0;
  localparam logic [1:0] GRP_NEWER = 2'd1;

  // Sequencer steps.
  typedef enum logic [1:0] {
    SEQ_FIRST,
    SEQ_LOW,
    SEQ_HDR
  } seq_e;

  // One decoded result on its way to the output register.
  typedef struct packed {
    logic [15:0] sample;
    logic        channel;
    logic        last;
    logic        error;
  } res_t;

  // Step adaptation factor, scaled by 256, for each nibble code.
  function automatic logic [9:0] adapt_factor(input logic [3:0] code);
    logic [9:0] f;
    case (code)
      4'd4, 4'd12: f = 10'd307;
      4'd5, 4'd11: f = 10'd409;
      4'd6, 4'd10: f = 10'd512;
      4'd7, 4'd9:  f = 10'd614;
      4'd8:        f = 10'd768;
      default:     f = 10'd230;
    endcase
    return f;
  endfunction

endpackage

### rtl/core/ms_adpcm_block_decoder_core.sv
// Top level of the ADPCM block decoder: stream ports, config registers, I/O registers.
//
//  Channel    Direction  Handshake                     Payload
//  s_axis     in         s_axis_tvalid/s_axis_tready   tdata: coef_index, coef_first,
//                                                      coef_second, data_byte; tuser: req_type
//  m_axis     out        m_axis_tvalid/m_axis_tready   tdata: sample; tuser: channel,
//                                                      predictor_error; tlast: block_last
//  cfg        in         cfg_we_i                      cfg_index_i, cfg_data_i
//
// A table write or a header byte other than the final one retires as soon as it
// is held; a data byte is decoded one nibble at a time (two in most cases) by the
// single nibble decoder that both nibbles go through. The final header byte is
// stored, then its 2 x channels header samples are sent. The input register takes
// the next item in the cycle the current one retires, so items follow with no gap,
// and an output register holds a result while the sink stalls. Reset clears control
// and channel state at once; the coefficient table has no clearing pass and is
// undefined until written.
module ms_adpcm_block_decoder_core import msadpcm_pkg::*; #(
  parameter int COEF_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // coef_index[7:0], coef_first[23:8],
                                      // coef_second[39:24], data_byte[47:40]
  input  logic        s_axis_tuser,   // req_type
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample[15:0]
  output logic [1:0]  m_axis_tuser,   // channel[0], predictor_error[1]
  output logic        m_axis_tlast,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic        in_valid_q, in_valid_d;
  logic [47:0] in_data_q;
  logic        in_type_q;
  logic        s_accept;
  logic        item_done;

  logic        out_valid_q, out_valid_d;
  res_t        out_q;
  logic        out_free;
  logic        emit_valid;
  res_t        emit;

  logic [1:0]  chan_cnt_q;
  logic [15:0] frames_q;
  logic [7:0]  coef_sets_q;
  logic        cfg_write;

  // Input register: refilled in the cycle its item retires.
  assign s_axis_tready = !in_valid_q || item_done;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_accept || (in_valid_q && !item_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata;
      in_type_q <= s_axis_tuser;
    end
  end

  // Configuration registers; only listed indexes count as writes.
  assign cfg_write = cfg_we_i && (cfg_index_i == CFG_CHANNELS ||
                                  cfg_index_i == CFG_FRAMES ||
                                  cfg_index_i == CFG_COEF_SETS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q  <= CHANNELS_RESET;
      frames_q    <= FRAMES_RESET;
      coef_sets_q <= COEF_SETS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CHANNELS:  chan_cnt_q  <= cfg_data_i[1:0];
        CFG_FRAMES:    frames_q    <= cfg_data_i;
        CFG_COEF_SETS: coef_sets_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer and decode datapath.
  msadpcm_seq #(
    .COEF_TABLE_DEPTH (COEF_TABLE_DEPTH)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (in_valid_q),
    .item_is_data_i (in_type_q),
    .coef_index_i   (in_data_q[7:0]),
    .coef_first_i   (in_data_q[23:8]),
    .coef_second_i  (in_data_q[39:24]),
    .data_byte_i    (in_data_q[47:40]),
    .out_free_i     (out_free),
    .cfg_write_i    (cfg_write),
    .stereo_i       (chan_cnt_q == CHANNELS_STEREO),
    .frames_i       (frames_q),
    .coef_sets_i    (coef_sets_q),
    .item_done_o    (item_done),
    .emit_valid_o   (emit_valid),
    .emit_o         (emit)
  );

  // Output register.
  assign out_free    = !out_valid_q || m_axis_tready;
  assign out_valid_d = emit_valid || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid) begin
      out_q <= emit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.sample;
  assign m_axis_tuser  = {out_q.error, out_q.channel};
  assign m_axis_tlast  = out_q.last;

endmodule

### rtl/core/msadpcm_coef_ram.sv
// Coefficient pair memory with one write port and one registered read port.
module msadpcm_coef_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/core/msadpcm_nibble_dec.sv
// Decodes one 4-bit code into a sample and the adapted step size.
module msadpcm_nibble_dec import msadpcm_pkg::*; (
  input  logic signed [15:0] newer_i,
  input  logic signed [15:0] older_i,
  input  logic        [15:0] step_i,
  input  logic signed [15:0] coef_first_i,
  input  logic signed [15:0] coef_second_i,
  input  logic        [3:0]  code_i,
  output logic        [15:0] sample_o,
  output logic        [15:0] step_o
);

  logic signed [31:0] prod_new;
  logic signed [31:0] prod_old;
  logic signed [32:0] acc;
  logic               neg_frac;
  logic signed [24:0] pred;
  logic signed [16:0] step_s;
  logic signed [3:0]  nib;
  logic signed [20:0] delta;
  logic signed [25:0] sum;
  logic        [25:0] step_prod;
  logic        [17:0] step_raw;

  // Two-tap prediction, divided by 256 with truncation toward zero.
  assign prod_new = newer_i * coef_first_i;
  assign prod_old = older_i * coef_second_i;
  assign acc      = {prod_new[31], prod_new} + {prod_old[31], prod_old};
  assign neg_frac = acc[32] && (acc[7:0] != 8'd0);
  assign pred     = $signed(acc[32:8]) + $signed({24'd0, neg_frac});

  // Add the signed code times the step, then clamp to 16 bits.
  assign step_s = $signed({1'b0, step_i});
  assign nib    = $signed(code_i);
  assign delta  = step_s * nib;
  assign sum    = {pred[24], pred} + {{5{delta[20]}}, delta};

  always_comb begin
    if (sum > SAMPLE_MAX) begin
      sample_o = 16'h7FFF;
    end else if (sum < SAMPLE_MIN) begin
      sample_o = 16'h8000;
    end else begin
      sample_o = sum[15:0];
    end
  end

  // Step adaptation with a floor, kept to 16 bits.
  assign step_prod = step_i * adapt_factor(code_i);
  assign step_raw  = (step_prod[25:8] < STEP_FLOOR) ? STEP_FLOOR : step_prod[25:8];
  assign step_o    = step_raw[15:0];

endmodule

### rtl/core/msadpcm_seq.sv
// Block sequencer: header parsing, channel state and one nibble decode per cycle while the output has room.
module msadpcm_seq import msadpcm_pkg::*; #(
  parameter int COEF_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  logic        item_is_data_i,
  input  logic [7:0]  coef_index_i,
  input  logic [15:0] coef_first_i,
  input  logic [15:0] coef_second_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_free_i,
  input  logic        cfg_write_i,
  input  logic        stereo_i,
  input  logic [15:0] frames_i,
  input  logic [7:0]  coef_sets_i,
  output logic        item_done_o,
  output logic        emit_valid_o,
  output res_t        emit_o
);

  localparam int AW = $clog2(COEF_TABLE_DEPTH);
  localparam logic [8:0] DEPTH_LIM = 9'(COEF_TABLE_DEPTH);

  seq_e        seq_q, seq_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [3:0]  byte_pos_q, byte_pos_d;
  logic [16:0] pending_q, pending_d;
  logic        blk_err_q, blk_err_d;
  logic [15:0] step_q [2];
  logic [15:0] step_d [2];
  logic [15:0] newer_q [2];
  logic [15:0] newer_d [2];
  logic [15:0] older_q [2];
  logic [15:0] older_d [2];
  logic [7:0]  pidx_q [2];
  logic [7:0]  pidx_d [2];
  logic [31:0] coef_q [2];
  logic [31:0] coef_d [2];
  logic        cap_valid_q, cap_valid_d;
  logic        cap_ch_q, cap_ch_d;
  logic        cap_zero_q, cap_zero_d;

  logic          ram_we;
  logic          ram_re;
  logic [31:0]   ram_rdata;
  logic          wr_in_range;
  logic          idx_in_range;

  logic        dec_ch;
  logic [3:0]  dec_code;
  logic [15:0] dec_sample;
  logic [15:0] dec_step;

  logic [3:0]  hdr_len;
  logic [3:0]  chans;
  logic [3:0]  pos;
  logic [3:0]  pos_n;
  logic [3:0]  k;
  logic [1:0]  grp;
  logic        hdr_ch;
  logic        hdr_hi;
  logic [15:0] fpb_m2;
  logic [16:0] pending_new;
  logic [1:0]  hdr_cnt_last;
  logic        hdr_out_ch;
  logic        hdr_out_newer;

  assign wr_in_range  = {1'b0, coef_index_i} < DEPTH_LIM;
  assign idx_in_range = {1'b0, data_byte_i} < DEPTH_LIM;

  // Coefficient table.
  msadpcm_coef_ram #(
    .DEPTH (COEF_TABLE_DEPTH),
    .AW    (AW)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (coef_index_i[AW-1:0]),
    .wdata_i ({coef_second_i, coef_first_i}),
    .re_i    (ram_re),
    .raddr_i (data_byte_i[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Nibble selection: high nibble on channel 0 first, low nibble second.
  assign dec_ch   = (seq_q == SEQ_LOW) && stereo_i;
  assign dec_code = (seq_q == SEQ_LOW) ? data_byte_i[3:0] : data_byte_i[7:4];

  msadpcm_nibble_dec u_nibble_dec (
    .newer_i       (newer_q[dec_ch]),
    .older_i       (older_q[dec_ch]),
    .step_i        (step_q[dec_ch]),
    .coef_first_i  (coef_q[dec_ch][15:0]),
    .coef_second_i (coef_q[dec_ch][31:16]),
    .code_i        (dec_code),
    .sample_o      (dec_sample),
    .step_o        (dec_step)
  );

  // Header position decode.
  assign hdr_len = stereo_i ? HDR_LEN_STEREO : HDR_LEN_MONO;
  assign chans   = stereo_i ? 4'd2 : 4'd1;
  assign pos     = (byte_pos_q >= hdr_len) ? 4'd0 : byte_pos_q;
  assign pos_n   = pos + 4'd1;
  assign k       = pos - chans;
  assign grp     = stereo_i ? k[3:2] : k[2:1];
  assign hdr_ch  = stereo_i && k[1];
  assign hdr_hi  = k[0];

  // Nibble samples in the block after the two header frames.
  assign fpb_m2      = (frames_i < 16'd2) ? 16'd0 : frames_i - 16'd2;
  assign pending_new = stereo_i ? {fpb_m2, 1'b0} : {1'b0, fpb_m2};

  // Header sample order: older of each channel, then newer of each channel.
  assign hdr_cnt_last  = stereo_i ? 2'd3 : 2'd1;
  assign hdr_out_ch    = stereo_i && hdr_cnt_q[0];
  assign hdr_out_newer = stereo_i ? hdr_cnt_q[1] : hdr_cnt_q[0];

  // Next state and outputs.
  always_comb begin
    seq_d        = seq_q;
    hdr_cnt_d    = hdr_cnt_q;
    byte_pos_d   = byte_pos_q;
    pending_d    = pending_q;
    blk_err_d    = blk_err_q;
    step_d       = step_q;
    newer_d      = newer_q;
    older_d      = older_q;
    pidx_d       = pidx_q;
    coef_d       = coef_q;
    cap_valid_d  = 1'b0;
    cap_ch_d     = cap_ch_q;
    cap_zero_d   = cap_zero_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    item_done_o  = 1'b0;
    emit_valid_o = 1'b0;
    emit_o       = '{sample: dec_sample, channel: dec_ch, last: 1'b0, error: blk_err_q};

    // Table entry read after a predictor byte lands in the channel copy.
    if (cap_valid_q) begin
      coef_d[cap_ch_q] = cap_zero_q ? 32'd0 : ram_rdata;
    end

    case (seq_q)
      SEQ_FIRST: begin
        if (item_valid_i && !item_is_data_i) begin
          // Coefficient write, mirrored into any channel that uses the entry.
          ram_we      = wr_in_range;
          item_done_o = 1'b1;
          for (int c = 0; c < 2; c++) begin
            if (wr_in_range && coef_index_i == pidx_q[c]) begin
              coef_d[c] = {coef_second_i, coef_first_i};
            end
          end
        end else if (item_valid_i && pending_q != 17'd0) begin
          // High nibble of a data byte.
          if (out_free_i) begin
            emit_valid_o        = 1'b1;
            emit_o.last         = pending_q == 17'd1;
            step_d[dec_ch]      = dec_step;
            older_d[dec_ch]     = newer_q[dec_ch];
            newer_d[dec_ch]     = dec_sample;
            pending_d           = pending_q - 17'd1;
            if (pending_q == 17'd1) begin
              byte_pos_d  = 4'd0;
              item_done_o = 1'b1;
            end else begin
              seq_d = SEQ_LOW;
            end
          end
        end else if (item_valid_i) begin
          // Header byte.
          if (pos == 4'd0) begin
            blk_err_d = 1'b0;
          end
          if (pos < chans) begin
            pidx_d[pos[0]] = data_byte_i;
            ram_re         = 1'b1;
            cap_valid_d    = 1'b1;
            cap_ch_d       = pos[0];
            cap_zero_d     = !idx_in_range;
            if (data_byte_i >= coef_sets_i || !idx_in_range) begin
              blk_err_d = 1'b1;
            end
          end else begin
            case (grp)
              GRP_STEP: begin
                if (hdr_hi) step_d[hdr_ch][15:8] = data_byte_i;
                else        step_d[hdr_ch][7:0]  = data_byte_i;
              end
              GRP_NEWER: begin
                if (hdr_hi) newer_d[hdr_ch][15:8] = data_byte_i;
                else        newer_d[hdr_ch][7:0]  = data_byte_i;
              end
              default: begin
                if (hdr_hi) older_d[hdr_ch][15:8] = data_byte_i;
                else        older_d[hdr_ch][7:0]  = data_byte_i;
              end
            endcase
          end
          if (pos_n < hdr_len) begin
            byte_pos_d  = pos_n;
            item_done_o = 1'b1;
          end else begin
            pending_d  = pending_new;
            byte_pos_d = (pending_new == 17'd0) ? 4'd0 : pos_n;
            hdr_cnt_d  = 2'd0;
            seq_d      = SEQ_HDR;
          end
        end
      end
      SEQ_LOW: begin
        // Low nibble of a data byte.
        if (out_free_i) begin
          emit_valid_o    = 1'b1;
          emit_o.last     = pending_q == 17'd1;
          step_d[dec_ch]  = dec_step;
          older_d[dec_ch] = newer_q[dec_ch];
          newer_d[dec_ch] = dec_sample;
          pending_d       = pending_q - 17'd1;
          if (pending_q == 17'd1) begin
            byte_pos_d = 4'd0;
          end
          item_done_o = 1'b1;
          seq_d       = SEQ_FIRST;
        end
      end
      SEQ_HDR: begin
        // Header samples, one per cycle while the output register has room.
        if (out_free_i) begin
          emit_valid_o   = 1'b1;
          emit_o.sample  = hdr_out_newer ? newer_q[hdr_out_ch] : older_q[hdr_out_ch];
          emit_o.channel = hdr_out_ch;
          emit_o.last    = (hdr_cnt_q == hdr_cnt_last) && (pending_q == 17'd0);
          if (hdr_cnt_q == hdr_cnt_last) begin
            item_done_o = 1'b1;
            seq_d       = SEQ_FIRST;
          end else begin
            hdr_cnt_d = hdr_cnt_q + 2'd1;
          end
        end
      end
      default: begin
        seq_d = SEQ_FIRST;
      end
    endcase

    // A register write restarts the parser at block start.
    if (cfg_write_i) begin
      byte_pos_d = 4'd0;
      pending_d  = 17'd0;
    end
  end

  // Control and channel state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_FIRST;
      hdr_cnt_q   <= 2'd0;
      byte_pos_q  <= 4'd0;
      pending_q   <= 17'd0;
      blk_err_q   <= 1'b0;
      step_q      <= '{default: '0};
      newer_q     <= '{default: '0};
      older_q     <= '{default: '0};
      pidx_q      <= '{default: '0};
      cap_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      hdr_cnt_q   <= hdr_cnt_d;
      byte_pos_q  <= byte_pos_d;
      pending_q   <= pending_d;
      blk_err_q   <= blk_err_d;
      step_q      <= step_d;
      newer_q     <= newer_d;
      older_q     <= older_d;
      pidx_q      <= pidx_d;
      cap_valid_q <= cap_valid_d;
    end
  end

  // Coefficient copies and capture bookkeeping.
  always_ff @(posedge clk_i) begin
    coef_q     <= coef_d;
    cap_ch_q   <= cap_ch_d;
    cap_zero_q <= cap_zero_d;
  end

  // A result is only produced when the output register can take it.
  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_valid_o |-> out_free_i) else $error("result produced without output room");

  // An item is only retired while one is held.
  a_done_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_done_o |-> item_valid_i) else $error("item retired with none held");

  // The low nibble step only runs with samples still owed.
  a_low_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_LOW) |-> (pending_q != 17'd0)) else $error("low nibble with no samples left");

  // The header position never passes the stereo header length.
  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_pos_q <= HDR_LEN_STEREO) else $error("header position out of range");

  // A finished block leaves the parser at block start.
  a_block_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid_o && emit_o.last) |=> (byte_pos_q == 4'd0))
    else $error("block end did not return to block start");

endmodule

### bench/ms_adpcm_tb_pkg.sv
// Item kinds and the spare register index shared by the decoder bench files.
package ms_adpcm_tb_pkg;

  // Kinds of input item carried on tuser.
  localparam logic REQ_COEF = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  // Register index with no register behind it.
  localparam logic [1:0] CFG_SPARE = 2'd3;

endpackage

### bench/ms_adpcm_block_decoder_checker.sv
// Sample predictor and result comparison for the ADPCM block decoder bench.
module ms_adpcm_block_decoder_checker
  import msadpcm_pkg::*;
  import ms_adpcm_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // coef_index, coef_first, coef_second, data_byte
  input  logic        s_axis_tuser,   // req_type
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // sample
  input  logic [1:0]  m_axis_tuser,   // channel, predictor_error
  input  logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          err_count_o,
  output int          pending_o
);

  // Coefficient table and per-channel decoder state.
  logic [31:0] coef_tbl [256];
  logic [15:0] step_q   [2];
  logic [15:0] newer_q  [2];
  logic [15:0] older_q  [2];
  logic [7:0]  pidx_q   [2];
  int unsigned hdr_pos;
  int unsigned nibbles_left;
  bit          blk_err;

  // Copy of the configuration registers.
  logic [1:0]  chan_code;
  logic [15:0] frames;
  logic [7:0]  sets_used;

  // Decoded samples still owed by the block, oldest first.
  res_t pcm_due [$];
  int   errs = 0;

  function automatic bit in_stereo();
    return chan_code == CHANNELS_STEREO;
  endfunction

  // Step growth factor in 1/256 units for a nibble code.
  function automatic int unsigned step_gain(input logic [3:0] code);
    case (code)
      4'd4, 4'd12: return 307;
      4'd5, 4'd11: return 409;
      4'd6, 4'd10: return 512;
      4'd7, 4'd9:  return 614;
      4'd8:        return 768;
      default:     return 230;
    endcase
  endfunction

  // Decode one nibble for a channel and advance that channel's state.
  task automatic decode_nibble(input int unsigned ch, input logic [3:0] code,
                               output logic [15:0] smp);
    logic [31:0] pair;
    longint      acc;
    longint      pred;
    int          nib;
    int unsigned grown;
    pair = coef_tbl[pidx_q[ch]];
    acc = longint'($signed(newer_q[ch])) * longint'($signed(pair[15:0])) +
          longint'($signed(older_q[ch])) * longint'($signed(pair[31:16]));
    // Division of a signed value truncates toward zero.
    pred = acc / 256;
    nib = code[3] ? int'(code) - 16 : int'(code);
    pred = pred + longint'(step_q[ch]) * nib;
    if (pred < -32768) pred = -32768;
    if (pred > 32767) pred = 32767;
    grown = step_q[ch] * step_gain(code) / 256;
    if (grown < 16) grown = 16;
    step_q[ch] = grown[15:0];
    older_q[ch] = newer_q[ch];
    newer_q[ch] = pred[15:0];
    smp = newer_q[ch];
  endtask

  task automatic owe_sample(input logic [15:0] smp, input logic ch, input bit last);
    res_t r;
    r.sample  = smp;
    r.channel = ch;
    r.last    = last;
    r.error   = blk_err;
    pcm_due.push_back(r);
  endtask

  // A register write also throws away any partly received block.
  task automatic apply_reg(input logic [1:0] idx, input logic [15:0] data);
    case (idx)
      CFG_CHANNELS:  chan_code = data[1:0];
      CFG_FRAMES:    frames = data;
      CFG_COEF_SETS: sets_used = data[7:0];
      default:       return;
    endcase
    hdr_pos = 0;
    nibbles_left = 0;
  endtask

  // Work out the samples that one accepted item causes.
  task automatic take_item(input logic kind, input logic [47:0] d);
    int unsigned c;
    int unsigned pos;
    int unsigned k;
    int unsigned grp;
    int unsigned slot;
    int unsigned ch;
    int unsigned fpb_eff;
    logic [7:0]  b;
    logic [15:0] smp;
    c = in_stereo() ? 2 : 1;
    b = d[47:40];
    if (kind == REQ_COEF) begin
      coef_tbl[d[7:0]] = {d[39:24], d[23:8]};
      return;
    end

    // Nibble pair: high nibble always goes to channel 0.
    if (nibbles_left > 0) begin
      decode_nibble(0, b[7:4], smp);
      nibbles_left--;
      owe_sample(smp, 1'b0, nibbles_left == 0);
      if (nibbles_left > 0) begin
        ch = (c == 2) ? 1 : 0;
        decode_nibble(ch, b[3:0], smp);
        nibbles_left--;
        owe_sample(smp, ch[0], nibbles_left == 0);
      end
      if (nibbles_left == 0) hdr_pos = 0;
      return;
    end

    // Header byte.
    pos = hdr_pos;
    if (pos >= 7 * c) pos = 0;
    if (pos == 0) blk_err = 1'b0;
    if (pos < c) begin
      pidx_q[pos] = b;
      if (b >= sets_used) blk_err = 1'b1;
    end else begin
      k = pos - c;
      grp = k / (2 * c);
      slot = k % (2 * c);
      ch = (slot >> 1) & 1;
      if (grp == GRP_STEP) step_q[ch][(slot % 2) * 8 +: 8] = b;
      else if (grp == GRP_NEWER) newer_q[ch][(slot % 2) * 8 +: 8] = b;
      else older_q[ch][(slot % 2) * 8 +: 8] = b;
    end
    pos++;
    if (pos < 7 * c) begin
      hdr_pos = pos;
      return;
    end

    // Header complete: older samples first, then newer ones.
    fpb_eff = (frames < 2) ? 2 : frames;
    nibbles_left = (fpb_eff - 2) * c;
    for (ch = 0; ch < c; ch++) owe_sample(older_q[ch], ch[0], 1'b0);
    for (ch = 0; ch < c; ch++)
      owe_sample(newer_q[ch], ch[0], nibbles_left == 0 && ch + 1 == c);
    hdr_pos = (nibbles_left == 0) ? 0 : pos;
  endtask

  // Compare results, then follow register writes and accepted items.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        step_q[i]  = '0;
        newer_q[i] = '0;
        older_q[i] = '0;
        pidx_q[i]  = '0;
      end
      hdr_pos      = 0;
      nibbles_left = 0;
      blk_err      = 1'b0;
      chan_code    = CHANNELS_RESET;
      frames       = FRAMES_RESET;
      sets_used    = COEF_SETS_RESET;
      pcm_due.delete();
      pending_o   <= 0;
      err_count_o <= errs;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.sample  = m_axis_tdata;
        got.channel = m_axis_tuser[0];
        got.last    = m_axis_tlast;
        got.error   = m_axis_tuser[1];
        if (pcm_due.size() == 0) begin
          errs++;
          $display("%0t: sample with none expected: got sample %h ch %0d last %0d err %0d",
                   $time, got.sample, got.channel, got.last, got.error);
        end else begin
          want = pcm_due.pop_front();
          if (got.sample !== want.sample || got.channel !== want.channel ||
              got.last !== want.last || got.error !== want.error) begin
            errs++;
            $display("%0t: mismatch: expected sample %h ch %0d last %0d err %0d, got sample %h ch %0d last %0d err %0d",
                     $time, want.sample, want.channel, want.last, want.error,
                     got.sample, got.channel, got.last, got.error);
          end
        end
      end
      if (cfg_we_i) apply_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) take_item(s_axis_tuser, s_axis_tdata);
      pending_o   <= pcm_due.size();
      err_count_o <= errs;
    end
  end

endmodule

### bench/tb_ms_adpcm_block_decoder_core.sv
// Stimulus and verdict for the ADPCM block decoder core.
module tb_ms_adpcm_block_decoder_core;
  import msadpcm_pkg::*;
  import ms_adpcm_tb_pkg::*;

  localparam int RUN_LIMIT       = 2_000_000;
  localparam int HOLD_OFF        = 24;
  localparam int ITEM_TARGET     = 330;
  localparam int BIG_BLOCK_BYTES = 40;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  int cycles = 0;
  int fails;
  int due;
  bit stall_free = 1'b0;

  // Coefficient entries written so far; predictors only ever select these.
  bit coef_written [256];
  int coef_list [$];

  // Configuration as last programmed.
  bit cur_stereo = 1'b0;
  int cur_frames = FRAMES_RESET;
  int cur_sets   = COEF_SETS_RESET;
  int items_sent = 0;

  ms_adpcm_block_decoder_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  ms_adpcm_block_decoder_checker pcm_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .err_count_o   (fails),
    .pending_o     (due)
  );

  always #1 clk = ~clk;

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("tb_ms_adpcm_block_decoder_core: done, errors");
      $finish;
    end
  end

  // The sink stalls about a third of the time outside the stall-free stretch.
  always @(posedge clk) begin
    m_tready <= stall_free || ($urandom_range(0, 99) >= 33);
  end

  // Offer one item, with random gaps first, and hold it until taken.
  task automatic push_item(input logic kind, input logic [47:0] d);
    while (!stall_free && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_coef(input logic [7:0] idx, input logic [15:0] first,
                           input logic [15:0] second);
    push_item(REQ_COEF, {8'($urandom), second, first, idx});
    if (!coef_written[idx]) begin
      coef_written[idx] = 1'b1;
      coef_list.push_back(idx);
    end
  endtask

  // Unused fields carry random bits.
  task automatic send_byte(input logic [7:0] b);
    push_item(REQ_BYTE, {b, 8'($urandom), 32'($urandom)});
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_step();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 64));
    return rand_word();
  endfunction

  task automatic send_random_coef();
    send_coef(8'($urandom_range(0, 255)), rand_word(), rand_word());
  endtask

  // Pick a written table entry, in or out of the valid range as asked.
  function automatic logic [7:0] pick_predictor(input bit want_err);
    int pool [$];
    foreach (coef_list[i])
      if ((coef_list[i] >= cur_sets) == want_err) pool.push_back(coef_list[i]);
    if (pool.size() == 0) pool = coef_list;
    return 8'(pool[$urandom_range(0, pool.size() - 1)]);
  endfunction

  // Let every owed sample arrive, then let the block settle.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // Write all three registers back to back; upper data bits carry noise.
  task automatic program_regs(input logic [1:0] code, input logic [15:0] frm,
                              input logic [7:0] sets, input bit poke_spare);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHANNELS;
    cfg_data  <= {14'($urandom), code};
    @(posedge clk);
    cfg_index <= CFG_FRAMES;
    cfg_data  <= frm;
    @(posedge clk);
    cfg_index <= CFG_COEF_SETS;
    cfg_data  <= {8'($urandom), sets};
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE;
      cfg_data  <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    cur_stereo = (code == CHANNELS_STEREO);
    cur_frames = frm;
    cur_sets   = sets;
  endtask

  task automatic reconfigure();
    logic [1:0]  code;
    logic [15:0] frm;
    logic [7:0]  sets;
    if ($urandom_range(0, 1) == 1) begin
      code = CHANNELS_STEREO;
    end else begin
      code = 2'($urandom_range(0, 3));
      if (code == CHANNELS_STEREO) code = CHANNELS_RESET;
    end
    case ($urandom_range(0, 9))
      0:       frm = 16'd0;
      1:       frm = 16'd1;
      2:       frm = 16'd2;
      3:       frm = 16'd3;
      default: frm = 16'($urandom_range(4, 40));
    endcase
    case ($urandom_range(0, 3))
      0:       sets = 8'd1;
      1:       sets = 8'd255;
      default: sets = 8'($urandom_range(1, 255));
    endcase
    program_regs(code, frm, sets, $urandom_range(0, 7) == 0);
  endtask

  // One well-formed block with random content, or its first part only.
  // A nonzero byte limit cuts the block after that many bytes.
  task automatic send_block(input bit broken, input int err_pct, input int max_bytes);
    logic [7:0]  bytes [$];
    logic [15:0] stp [2];
    logic [15:0] nw [2];
    logic [15:0] od [2];
    logic [7:0]  pr [2];
    int c;
    int fe;
    int n_data;
    int stop;
    c = cur_stereo ? 2 : 1;
    for (int ch = 0; ch < 2; ch++) begin
      pr[ch]  = pick_predictor($urandom_range(0, 99) < err_pct);
      stp[ch] = rand_step();
      nw[ch]  = rand_word();
      od[ch]  = rand_word();
    end
    for (int ch = 0; ch < c; ch++) bytes.push_back(pr[ch]);
    for (int ch = 0; ch < c; ch++) begin
      bytes.push_back(stp[ch][7:0]);
      bytes.push_back(stp[ch][15:8]);
    end
    for (int ch = 0; ch < c; ch++) begin
      bytes.push_back(nw[ch][7:0]);
      bytes.push_back(nw[ch][15:8]);
    end
    for (int ch = 0; ch < c; ch++) begin
      bytes.push_back(od[ch][7:0]);
      bytes.push_back(od[ch][15:8]);
    end
    fe = (cur_frames < 2) ? 2 : cur_frames;
    n_data = cur_stereo ? fe - 2 : (fe - 1) / 2;
    repeat (n_data) bytes.push_back(8'($urandom));
    stop = broken ? $urandom_range(1, bytes.size() - 1) : bytes.size();
    if (max_bytes > 0 && stop > max_bytes) stop = max_bytes;
    // Table writes may land anywhere inside the block.
    for (int i = 0; i < stop; i++) begin
      if ($urandom_range(0, 11) == 0) send_random_coef();
      send_byte(bytes[i]);
    end
  endtask

  localparam logic [7:0] OPEN_BYTES [9] = '{8'h01, 8'h10, 8'h00, 8'h00, 8'h01,
                                            8'h00, 8'hFF, 8'h7F, 8'h80};
  localparam logic [7:0] SHORT_BYTES [7] = '{8'h07, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                                             8'h00, 8'h80};
  localparam logic [7:0] ODD_BYTES [9] = '{8'h07, 8'hFF, 8'hFF, 8'h00, 8'h80,
                                           8'hFF, 8'h7F, 8'h87, 8'h9F};

  initial begin
    int rnd_base;
    int span;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Table entries with ordinary and extreme weights.
    send_coef(8'd0, 16'd256, 16'd0);
    send_coef(8'd1, 16'd512, -16'sd256);
    send_coef(8'd7, 16'h8000, 16'h7FFF);
    send_coef(8'd8, 16'h7FFF, 16'h8000);
    send_coef(8'd255, 16'h7FFF, 16'h7FFF);

    // Default settings, block dropped mid-data by the next register write.
    foreach (OPEN_BYTES[i]) send_byte(OPEN_BYTES[i]);

    // Short block: header samples only, predictor out of range.
    program_regs(2'd1, 16'd1, 8'd7, 1'b1);
    foreach (SHORT_BYTES[i]) send_byte(SHORT_BYTES[i]);

    // Odd nibble count in mono with saturating steps.
    program_regs(2'd3, 16'd5, 8'd255, 1'b0);
    foreach (ODD_BYTES[i]) send_byte(ODD_BYTES[i]);

    // Random blocks, some cut short, with a stretch free of stalls.
    rnd_base = items_sent;
    while (items_sent - rnd_base < ITEM_TARGET) begin
      span = items_sent - rnd_base;
      stall_free <= (span >= 150 && span < 230);
      if ($urandom_range(0, 99) < 20) reconfigure();
      if ($urandom_range(0, 99) < 12) begin
        send_block(1'b1, 20, 0);
        reconfigure();
      end else begin
        send_block(1'b0, 20, 0);
      end
    end
    stall_free <= 1'b0;

    // A stereo block of the largest size, cut after its first data bytes.
    program_regs(CHANNELS_STEREO, 16'hFFFF, 8'd7, 1'b0);
    send_block(1'b0, 0, BIG_BLOCK_BYTES);

    wait_quiet();
    if (fails == 0) begin
      $display("tb_ms_adpcm_block_decoder_core: done, clean");
    end else begin
      $display("tb_ms_adpcm_block_decoder_core: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/msadpcm_pkg.sv
rtl/core/msadpcm_coef_ram.sv
rtl/core/msadpcm_nibble_dec.sv
rtl/core/msadpcm_seq.sv
rtl/core/ms_adpcm_block_decoder_core.sv
bench/ms_adpcm_tb_pkg.sv
bench/ms_adpcm_block_decoder_checker.sv
bench/tb_ms_adpcm_block_decoder_core.sv
